/* design/nks_pkg.sv */
// nks_pkg: shared types and codes for the nearest-key ordered set.
// Used by nks_ram, nearest_key_set_remove and its checker.
package nks_pkg;
  localparam int DefCapacity = 256;
  localparam int KeyW = 31;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_EXISTS   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_REMOVED  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic            action;
    logic [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [KeyW-1:0] removed_key;
  } rsp_t;
endpackage

/* design/nks_ram.sv */
// nks_ram: single write port, single read port memory, registered read data.
// Depends on nks_pkg for the key width.
module nks_ram #(
  parameter int Depth = nks_pkg::DefCapacity,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AddrW-1:0]        waddr,
  input  logic [nks_pkg::KeyW-1:0] wdata,
  input  logic [AddrW-1:0]        raddr,
  output logic [nks_pkg::KeyW-1:0] rdata
);
  import nks_pkg::*;

  logic [KeyW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/nearest_key_set_remove.sv */
// Binary search takes at most ceil(log2(n+1)) steps over n stored keys; when the set
// changes, entries are then moved (keys above the insert point, or after the removed
// key). Search and moves share one memory read port. One item in flight; a finished
// result waits while the previous one is stalled at the output, and the next item is
// taken the cycle after the result is registered.
// Reset (synchronous) empties the set; memory contents need no clearing.
// Depends on nks_pkg and nks_ram.
module nearest_key_set_remove #(
  parameter int CAPACITY = nks_pkg::DefCapacity
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  nks_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output nks_pkg::rsp_t rsp
);
  import nks_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_CMP  = 4'd2;
  localparam logic [3:0] S_RDHI = 4'd3;
  localparam logic [3:0] S_RDLO = 4'd4;
  localparam logic [3:0] S_DEC  = 4'd5;
  localparam logic [3:0] S_MVRD = 4'd6;
  localparam logic [3:0] S_MVWR = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]      state;
  logic [PW-1:0]   lo, hi, mid, pos, idx, occ;
  logic            act_q;
  logic [KeyW-1:0] key_q, above_key, removed_q;
  logic [2:0]      status_q;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [KeyW-1:0] wdata, rdata;

  logic            hit;
  logic [KeyW-1:0] below_dist, above_dist;
  logic [PW-1:0]   pick;
  logic [PW-1:0]   mid_next, pos_dec, idx_inc, idx_dec;

  nks_ram #(.Depth(CAPACITY), .AddrW(AW)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign req_stall  = (state != S_IDLE);
  assign hit        = (pos < occ) && (above_key == key_q);
  assign below_dist = key_q - rdata;
  assign above_dist = above_key - key_q;
  assign mid_next   = lo + ((hi - lo) >> 1);
  assign pos_dec    = pos - PW'(1);
  assign idx_inc    = idx + PW'(1);
  assign idx_dec    = idx - PW'(1);

  always_comb begin
    if (hit) begin
      pick = pos;
    end else if (pos == '0) begin
      pick = '0;
    end else if (pos == occ) begin
      pick = occ - PW'(1);
    end else if (below_dist <= above_dist) begin
      pick = pos_dec;
    end else begin
      pick = pos;
    end
  end

  always_comb begin
    raddr = mid[AW-1:0];
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    unique case (state)
      S_SRCH: begin
        raddr = mid_next[AW-1:0];
      end
      S_RDHI: raddr = pos[AW-1:0];
      S_RDLO: raddr = pos_dec[AW-1:0];
      S_MVRD: begin
        if (act_q) begin
          raddr = idx_inc[AW-1:0];
        end else begin
          raddr = idx_dec[AW-1:0];
          if (idx <= pos) begin
            we    = 1'b1;
            waddr = pos[AW-1:0];
            wdata = key_q;
          end
        end
      end
      S_MVWR: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            act_q <= req.action;
            key_q <= req.key;
            lo    <= '0;
            hi    <= occ;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          mid <= mid_next;
          if (lo < hi) begin
            state <= S_CMP;
          end else begin
            pos   <= lo;
            state <= S_RDHI;
          end
        end
        S_CMP: begin
          if (rdata < key_q) begin
            lo <= mid + PW'(1);
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_RDHI: state <= S_RDLO;
        S_RDLO: begin
          above_key <= rdata;
          state     <= S_DEC;
        end
        S_DEC: begin
          removed_q <= '0;
          if (!act_q) begin
            if (hit) begin
              status_q <= ST_EXISTS;
              state    <= S_FIN;
            end else if (occ == PW'(CAPACITY)) begin
              status_q <= ST_FULL;
              state    <= S_FIN;
            end else begin
              status_q <= ST_INSERTED;
              idx      <= occ;
              state    <= S_MVRD;
            end
          end else if (occ == '0) begin
            status_q <= ST_EMPTY;
            state    <= S_FIN;
          end else begin
            status_q  <= ST_REMOVED;
            idx       <= pick;
            removed_q <= (pick == pos) ? above_key : rdata;
            state     <= S_MVRD;
          end
        end
        S_MVRD: begin
          if (act_q) begin
            if (idx_inc < occ) begin
              state <= S_MVWR;
            end else begin
              occ   <= occ - PW'(1);
              state <= S_FIN;
            end
          end else if (idx > pos) begin
            state <= S_MVWR;
          end else begin
            occ   <= occ + PW'(1);
            state <= S_FIN;
          end
        end
        S_MVWR: begin
          idx   <= act_q ? idx_inc : idx_dec;
          state <= S_MVRD;
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            rsp.status      <= status_q;
            rsp.removed_key <= removed_q;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/nks_checker.sv */
// nks_checker: port-level checks for nearest_key_set_remove, bound into that module.
// Depends on nks_pkg.
module nks_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input nks_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input nks_pkg::rsp_t rsp
);
  import nks_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_INSERTED || rsp.status == ST_EXISTS ||
                   rsp.status == ST_EMPTY || rsp.status == ST_REMOVED ||
                   rsp.status == ST_FULL))
    else $error("bad status code");

  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_REMOVED) |-> (rsp.removed_key == '0))
    else $error("removed_key set without removal");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled item changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!rsp_valid && !req_stall))
    else $error("not idle after reset");

  a_one_per_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("item accepted while busy");
endmodule

bind nearest_key_set_remove nks_checker u_nks_checker (
  .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp
);
